@@ design/bgg_pkg.sv @@
package bgg_pkg;

    localparam int MAX_BEATS = 16;
    localparam int BEAT_W    = 4;
    localparam int SUB_W     = 4;
    localparam int MEAS_W    = 16;
    localparam int FRAME_W   = 31;
    localparam int DUR_W     = 31;
    localparam int ATOM_W    = 8;
    localparam int NB_W      = 5;
    localparam int LEN_W     = 64;
    localparam int IDX_W     = 3;
    localparam int CFG_W     = 64;
    localparam int PRE_W     = 40;   // prefix sums of per-beat offsets
    localparam int PROD_W    = 47;   // measure offset times duration
    localparam int POS_W     = 49;   // full-width grid position
    localparam int NEED_W    = 42;
    localparam int DIVD_W    = 36;   // dividend / quotient width
    localparam int RADDR_W   = 5;    // prefix address 0..MAX_BEATS
    localparam int OPOS_W    = 32;
    localparam int PROM_W    = 3;
    localparam int EVEN_DIV  = 2;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_NEXT  = 1'b1;

    typedef enum logic [PROM_W-1:0] {
        PROM_SEGMENT,
        PROM_MEASURE,
        PROM_BEAT,
        PROM_EVEN,
        PROM_OTHER
    } prom_t;

    typedef enum logic [IDX_W-1:0] {
        CFG_SEG_START,
        CFG_SEG_END,
        CFG_FIRST_MEAS,
        CFG_DURATION,
        CFG_ATOMS,
        CFG_BEATS,
        CFG_LENGTHS
    } cfg_idx_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_RF_DIV,
        OP_RF_ACC,
        OP_ADV,
        OP_NX_DIV,
        OP_NX_POS,
        OP_NX_END,
        OP_OM_DIV,
        OP_OM_NEED,
        OP_K_DIV,
        OP_K_SET,
        OP_K_ZERO,
        OP_BASE,
        OP_BEAT_INC,
        OP_S_DIV,
        OP_S_NEXT,
        OP_FOUND,
        OP_RESTART
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_RF_DIV,
        ST_RF_WAIT,
        ST_ADV,
        ST_NX_DIV,
        ST_NX_WAIT,
        ST_NX_END,
        ST_OM_DIV,
        ST_OM_WAIT,
        ST_NEED_CHK,
        ST_K_DIV,
        ST_K_WAIT,
        ST_BASE,
        ST_SCAN,
        ST_S_DIV,
        ST_S_WAIT,
        ST_FAIL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [FRAME_W-1:0] seg_start;
        logic [FRAME_W-1:0] seg_end;
        logic [MEAS_W-1:0]  first_measure;
        logic [DUR_W-1:0]   duration;
        logic [ATOM_W-1:0]  atom_count;
        logic [NB_W-1:0]    beats;
        logic [LEN_W-1:0]   lengths;
    } cfg_t;

    typedef struct packed {
        logic dirty;
        logic is_next;
        logic div_done;
        logic rf_last;
        logic need_pos;
        logic dur_zero;
        logic k_ovf;
        logic beat_past;
        logic beat_last;
        logic hit;
        logic sub_last;
    } stat_t;

    typedef struct packed {
        logic [OPOS_W-1:0] position;
        prom_t             prominence;
        logic [MEAS_W-1:0] measure;
        logic [BEAT_W-1:0] beat;
        logic [SUB_W-1:0]  subdiv;
        logic              crossed;
    } res_t;

    // beat length, zero read as one
    function automatic logic [SUB_W-1:0] blen(input logic [LEN_W-1:0] lens,
                                              input logic [BEAT_W-1:0] b);
        logic [SUB_W-1:0] l;
        l = lens[b*SUB_W +: SUB_W];
        return (l == '0) ? SUB_W'(1) : l;
    endfunction

    function automatic logic [NB_W-1:0] nbeats(input logic [NB_W-1:0] n);
        logic [NB_W-1:0] r;
        r = n;
        if (n == '0)
            r = NB_W'(1);
        else if (n > NB_W'(MAX_BEATS))
            r = NB_W'(MAX_BEATS);
        return r;
    endfunction

    function automatic logic [ATOM_W-1:0] atoms(input logic [ATOM_W-1:0] a);
        return (a == '0) ? ATOM_W'(1) : a;
    endfunction

endpackage

@@ design/bgg_div.sv @@
module bgg_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [bgg_pkg::DIVD_W-1:0] dividend,
    input  logic [bgg_pkg::DUR_W-1:0]  divisor,
    output logic                       done,
    output logic [bgg_pkg::DIVD_W-1:0] quotient
);
    import bgg_pkg::*;

    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DUR_W-1:0]  rem_reg, rem_next;
    logic [DUR_W-1:0]  dvs_reg, dvs_next;
    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [DUR_W+1:0]  diff_c;

    // one restoring step per cycle
    assign diff_c = {1'b0, rem_reg, quo_reg[DIVD_W-1]} - {2'b00, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVD_W);
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            if (!diff_c[DUR_W+1])
            begin
                rem_next = diff_c[DUR_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[DUR_W-2:0], quo_reg[DIVD_W-1]};
                quo_next = {quo_reg[DIVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ design/bgg_dp.sv @@
module bgg_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bgg_pkg::cfg_t               cfg,
    input  logic                        cfg_wr,
    input  logic                        in_cmd,
    input  logic [bgg_pkg::FRAME_W-1:0] in_sf,
    input  bgg_pkg::op_t                op,
    output bgg_pkg::stat_t              stat,
    output bgg_pkg::res_t               res
);
    import bgg_pkg::*;

    // mem[i] holds the offset of beat i+1 from the measure start
    logic [PRE_W-1:0]   mem [0:MAX_BEATS-1];

    logic [MEAS_W-1:0]  meas_reg, meas_next;
    logic [BEAT_W-1:0]  beat_reg, beat_next;
    logic [SUB_W-1:0]   sub_reg, sub_next;
    logic               dirty_reg, dirty_next;
    logic [BEAT_W-1:0]  idx_reg, idx_next;
    logic [SUB_W-1:0]   s_reg, s_next;

    logic               cmd_reg;
    logic [FRAME_W-1:0] sf_reg;
    logic               crossed_reg;
    logic [PRE_W-1:0]   acc_reg;
    logic [PRE_W-1:0]   pre_rd_reg;
    logic [PRE_W-1:0]   lo_reg;
    logic [NEED_W-1:0]  need_reg;
    logic [MEAS_W-1:0]  k_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [POS_W-1:0]   base_reg;
    logic [POS_W-1:0]   pos_reg;

    logic [NB_W-1:0]    nb_c;
    logic [BEAT_W-1:0]  last_beat_c;
    logic [SUB_W-1:0]   mop_c;
    logic [DUR_W+SUB_W-1:0] dm_c;
    logic [DIVD_W-1:0]  dividend_c;
    logic [DUR_W-1:0]   divisor_c;
    logic               div_start_c;
    logic               div_done;
    logic [DIVD_W-1:0]  q_c;
    logic [MEAS_W-1:0]  mul_a_c;
    logic [PROD_W-1:0]  mul_c;
    logic               rd_en_c;
    logic [RADDR_W-1:0] rd_addr_c;
    logic [BEAT_W-1:0]  rd_mem_c;
    logic [POS_W-1:0]   nx_pos_c;
    logic [POS_W-1:0]   pt_c;
    logic [POS_W-1:0]   past_c;
    logic [NEED_W-1:0]  need_c;
    logic [SUB_W-1:0]   len_beat_c;
    logic [SUB_W-1:0]   len_idx_c;
    prom_t              prom_c;

    assign nb_c        = nbeats(cfg.beats);
    assign last_beat_c = BEAT_W'(nb_c - NB_W'(1));
    assign len_beat_c  = blen(cfg.lengths, beat_reg);
    assign len_idx_c   = blen(cfg.lengths, idx_reg);

    // divider operand selection
    always_comb
    begin
        case (op)
            OP_RF_DIV: mop_c = len_idx_c;
            OP_NX_DIV: mop_c = sub_reg;
            OP_OM_DIV: mop_c = blen(cfg.lengths, last_beat_c) - SUB_W'(1);
            OP_S_DIV:  mop_c = s_reg;
            default:   mop_c = '0;
        endcase
    end

    assign dm_c        = (DUR_W+SUB_W)'(cfg.duration) * (DUR_W+SUB_W)'(mop_c);
    assign div_start_c = (op == OP_RF_DIV) || (op == OP_NX_DIV) || (op == OP_OM_DIV)
                      || (op == OP_K_DIV)  || (op == OP_S_DIV);
    assign dividend_c  = (op == OP_K_DIV)
                       ? DIVD_W'(need_reg[DUR_W:0]) + DIVD_W'(cfg.duration) - DIVD_W'(1)
                       : DIVD_W'(dm_c);
    assign divisor_c   = (op == OP_K_DIV) ? cfg.duration : DUR_W'(atoms(cfg.atom_count));

    bgg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_c),
        .dividend (dividend_c),
        .divisor  (divisor_c),
        .done     (div_done),
        .quotient (q_c)
    );

    // measure offset times duration, shared by next and search paths
    assign mul_a_c = (op == OP_BASE) ? k_reg : (meas_reg - cfg.first_measure);
    assign mul_c   = PROD_W'(mul_a_c) * PROD_W'(cfg.duration);

    // prefix read port
    always_comb
    begin
        rd_en_c   = 1'b1;
        rd_addr_c = '0;
        case (op)
            OP_NX_DIV:   rd_addr_c = RADDR_W'(beat_reg);
            OP_OM_DIV:   rd_addr_c = RADDR_W'(last_beat_c);
            OP_BASE:     rd_addr_c = RADDR_W'(1);
            OP_BEAT_INC: rd_addr_c = RADDR_W'(idx_reg) + RADDR_W'(2);
            default:     rd_en_c   = 1'b0;
        endcase
    end
    assign rd_mem_c = BEAT_W'(rd_addr_c - RADDR_W'(1));

    always_ff @(posedge clk)
    begin
        if (op == OP_RF_ACC)
            mem[idx_reg] <= acc_reg + PRE_W'(q_c);
        if (rd_en_c)
            pre_rd_reg <= (rd_addr_c == '0) ? '0 : mem[rd_mem_c];
    end

    assign nx_pos_c = POS_W'(cfg.seg_start) + POS_W'(prod_reg) + POS_W'(pre_rd_reg)
                    + POS_W'(q_c);
    assign pt_c     = base_reg + POS_W'(lo_reg) + POS_W'(q_c);
    assign past_c   = base_reg + POS_W'(pre_rd_reg);
    assign need_c   = NEED_W'(sf_reg) - NEED_W'(cfg.seg_start) - NEED_W'(pre_rd_reg)
                    - NEED_W'(q_c);

    // counters and control state
    always_comb
    begin
        meas_next  = meas_reg;
        beat_next  = beat_reg;
        sub_next   = sub_reg;
        dirty_next = dirty_reg;
        idx_next   = idx_reg;
        s_next     = s_reg;
        case (op)
            OP_LOAD:
            begin
                idx_next = '0;
            end
            OP_RF_ACC:
            begin
                idx_next = idx_reg + BEAT_W'(1);
                if (idx_reg == BEAT_W'(MAX_BEATS - 1))
                    dirty_next = 1'b0;
            end
            OP_ADV:
            begin
                if ({1'b0, sub_reg} + 5'd1 >= {1'b0, len_beat_c})
                begin
                    sub_next = '0;
                    if (NB_W'(beat_reg) + NB_W'(1) >= nb_c)
                    begin
                        beat_next = '0;
                        meas_next = meas_reg + MEAS_W'(1);
                    end
                    else
                        beat_next = beat_reg + BEAT_W'(1);
                end
                else
                    sub_next = sub_reg + SUB_W'(1);
            end
            OP_NX_END:
            begin
                if ((cfg.seg_start != cfg.seg_end) && (pos_reg >= POS_W'(cfg.seg_end)))
                begin
                    meas_next = cfg.first_measure;
                    beat_next = '0;
                    sub_next  = '0;
                end
            end
            OP_BASE:
            begin
                idx_next = '0;
                s_next   = '0;
            end
            OP_BEAT_INC:
            begin
                idx_next = idx_reg + BEAT_W'(1);
                s_next   = '0;
            end
            OP_S_NEXT:
            begin
                s_next = s_reg + SUB_W'(1);
            end
            OP_FOUND:
            begin
                meas_next = cfg.first_measure + k_reg;
                beat_next = idx_reg;
                sub_next  = s_reg;
            end
            OP_RESTART:
            begin
                meas_next = cfg.first_measure;
                beat_next = '0;
                sub_next  = '0;
            end
            default:
            begin
            end
        endcase
        if (cfg_wr)
            dirty_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meas_reg  <= '0;
            beat_reg  <= '0;
            sub_reg   <= '0;
            dirty_reg <= 1'b1;
            idx_reg   <= '0;
            s_reg     <= '0;
        end
        else
        begin
            meas_reg  <= meas_next;
            beat_reg  <= beat_next;
            sub_reg   <= sub_next;
            dirty_reg <= dirty_next;
            idx_reg   <= idx_next;
            s_reg     <= s_next;
        end
    end

    // working values
    always_ff @(posedge clk)
    begin
        case (op)
            OP_LOAD:
            begin
                cmd_reg     <= in_cmd;
                sf_reg      <= in_sf;
                crossed_reg <= 1'b0;
                acc_reg     <= '0;
            end
            OP_RF_ACC:   acc_reg  <= acc_reg + PRE_W'(q_c);
            OP_NX_DIV:   prod_reg <= mul_c;
            OP_NX_POS:   pos_reg  <= nx_pos_c;
            OP_NX_END:
            begin
                if ((cfg.seg_start != cfg.seg_end) && (pos_reg >= POS_W'(cfg.seg_end)))
                begin
                    pos_reg     <= POS_W'(cfg.seg_start);
                    crossed_reg <= 1'b1;
                end
            end
            OP_OM_NEED:  need_reg <= need_c;
            OP_K_SET:    k_reg    <= q_c[MEAS_W-1:0];
            OP_K_ZERO:   k_reg    <= '0;
            OP_BASE:
            begin
                base_reg <= POS_W'(cfg.seg_start) + POS_W'(mul_c);
                lo_reg   <= '0;
            end
            OP_BEAT_INC: lo_reg   <= pre_rd_reg;
            OP_FOUND:    pos_reg  <= pt_c;
            OP_RESTART:
            begin
                pos_reg     <= POS_W'(cfg.seg_start);
                crossed_reg <= 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if ((meas_reg == cfg.first_measure) && (beat_reg == '0) && (sub_reg == '0))
            prom_c = PROM_SEGMENT;
        else if ((sub_reg == '0) && (beat_reg == '0))
            prom_c = PROM_MEASURE;
        else if (sub_reg == '0)
            prom_c = PROM_BEAT;
        else if ((len_beat_c % EVEN_DIV == 0) && (sub_reg % EVEN_DIV == 0))
            prom_c = PROM_EVEN;
        else
            prom_c = PROM_OTHER;
    end

    always_comb
    begin
        stat.dirty     = dirty_reg;
        stat.is_next   = (cmd_reg == CMD_NEXT);
        stat.div_done  = div_done;
        stat.rf_last   = (idx_reg == BEAT_W'(MAX_BEATS - 1));
        stat.need_pos  = !need_reg[NEED_W-1] && (need_reg != '0);
        stat.dur_zero  = (cfg.duration == '0);
        stat.k_ovf     = (q_c[DIVD_W-1:MEAS_W] != '0);
        stat.beat_past = past_c < POS_W'(sf_reg);
        stat.beat_last = (NB_W'(idx_reg) + NB_W'(1) >= nb_c);
        stat.hit       = pt_c >= POS_W'(sf_reg);
        stat.sub_last  = ({1'b0, s_reg} + 5'd1 >= {1'b0, len_idx_c});
    end

    assign res.position   = pos_reg[OPOS_W-1:0];
    assign res.prominence = prom_c;
    assign res.measure    = meas_reg;
    assign res.beat       = beat_reg;
    assign res.subdiv     = sub_reg;
    assign res.crossed    = crossed_reg;

endmodule

@@ design/bgg_ctrl.sv @@
module bgg_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           out_free,
    output logic           out_load,
    input  bgg_pkg::stat_t stat,
    output bgg_pkg::op_t   op
);
    import bgg_pkg::*;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (in_valid) state_next = ST_DISPATCH;
            ST_DISPATCH:
            begin
                if (stat.dirty)
                    state_next = ST_RF_DIV;
                else if (stat.is_next)
                    state_next = ST_ADV;
                else
                    state_next = ST_OM_DIV;
            end
            ST_RF_DIV:   state_next = ST_RF_WAIT;
            ST_RF_WAIT:
                if (stat.div_done)
                    state_next = stat.rf_last ? ST_DISPATCH : ST_RF_DIV;
            ST_ADV:      state_next = ST_NX_DIV;
            ST_NX_DIV:   state_next = ST_NX_WAIT;
            ST_NX_WAIT:  if (stat.div_done) state_next = ST_NX_END;
            ST_NX_END:   state_next = ST_DONE;
            ST_OM_DIV:   state_next = ST_OM_WAIT;
            ST_OM_WAIT:  if (stat.div_done) state_next = ST_NEED_CHK;
            ST_NEED_CHK:
            begin
                if (!stat.need_pos)
                    state_next = ST_BASE;
                else if (stat.dur_zero)
                    state_next = ST_FAIL;
                else
                    state_next = ST_K_DIV;
            end
            ST_K_DIV:    state_next = ST_K_WAIT;
            ST_K_WAIT:
                if (stat.div_done)
                    state_next = stat.k_ovf ? ST_FAIL : ST_BASE;
            ST_BASE:     state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (!stat.beat_past)
                    state_next = ST_S_DIV;
                else if (stat.beat_last)
                    state_next = ST_FAIL;
            end
            ST_S_DIV:    state_next = ST_S_WAIT;
            ST_S_WAIT:
            begin
                if (stat.div_done)
                begin
                    if (stat.hit)
                        state_next = ST_DONE;
                    else if (!stat.sub_last)
                        state_next = ST_S_DIV;
                    else if (stat.beat_last)
                        state_next = ST_FAIL;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_FAIL:     state_next = ST_DONE;
            ST_DONE:     if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        op       = OP_NONE;
        in_ready = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    op = OP_LOAD;
            end
            ST_RF_DIV:   op = OP_RF_DIV;
            ST_RF_WAIT:  if (stat.div_done) op = OP_RF_ACC;
            ST_ADV:      op = OP_ADV;
            ST_NX_DIV:   op = OP_NX_DIV;
            ST_NX_WAIT:  if (stat.div_done) op = OP_NX_POS;
            ST_NX_END:   op = OP_NX_END;
            ST_OM_DIV:   op = OP_OM_DIV;
            ST_OM_WAIT:  if (stat.div_done) op = OP_OM_NEED;
            ST_NEED_CHK: if (!stat.need_pos) op = OP_K_ZERO;
            ST_K_DIV:    op = OP_K_DIV;
            ST_K_WAIT:   if (stat.div_done && !stat.k_ovf) op = OP_K_SET;
            ST_BASE:     op = OP_BASE;
            ST_SCAN:     if (stat.beat_past && !stat.beat_last) op = OP_BEAT_INC;
            ST_S_DIV:    op = OP_S_DIV;
            ST_S_WAIT:
            begin
                if (stat.div_done)
                begin
                    if (stat.hit)
                        op = OP_FOUND;
                    else if (!stat.sub_last)
                        op = OP_S_NEXT;
                    else if (!stat.beat_last)
                        op = OP_BEAT_INC;
                end
            end
            ST_FAIL:     op = OP_RESTART;
            ST_DONE:     out_load = out_free;
            default:     op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ design/beat_grid_generator_top.sv @@
// Beat grid generator: one tempo segment with per-beat subdivision counts.
// A next item runs one 36-step divide for the subdivision offset; a start item runs
//   one divide for the last point, a measure divide when the origin lies past the
//   first measure, one per subdivision scanned, and skips beats without a divide.
// After any config write the first item first rebuilds the 16 per-beat offsets with
//   the same divider. One item in flight at a time.
// Reset (rst_n low, async): counters to zero, config to defaults, output empty.
module beat_grid_generator_top (
    input  logic        clk,
    input  logic        rst_n,
    // config write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [30:0] search origin, [31] zero
    input  logic        s_tuser,   // cmd: 0 start search, 1 next point
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [31:0] position, [47:32] measure_number,
                                   // [51:48] beat_number, [55:52] subdiv_number
    output logic [3:0]  m_tuser    // [2:0] prominence, [3] segment_crossed
);
    import bgg_pkg::*;

    cfg_t   cfg_reg, cfg_next;
    op_t    op;
    stat_t  stat;
    res_t   res;
    logic   in_ready;
    logic   out_free;
    logic   out_load;
    logic   m_valid_reg, m_valid_next;
    res_t   m_res_reg;

    // config registers; written by user only while no item in flight; unenforced
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SEG_START:  cfg_next.seg_start     = cfg_data[FRAME_W-1:0];
                CFG_SEG_END:    cfg_next.seg_end       = cfg_data[FRAME_W-1:0];
                CFG_FIRST_MEAS: cfg_next.first_measure = cfg_data[MEAS_W-1:0];
                CFG_DURATION:   cfg_next.duration      = cfg_data[DUR_W-1:0];
                CFG_ATOMS:      cfg_next.atom_count    = cfg_data[ATOM_W-1:0];
                CFG_BEATS:      cfg_next.beats         = cfg_data[NB_W-1:0];
                CFG_LENGTHS:    cfg_next.lengths       = cfg_data[LEN_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.seg_start     <= '0;
            cfg_reg.seg_end       <= '0;
            cfg_reg.first_measure <= '0;
            cfg_reg.duration      <= DUR_W'(96000);
            cfg_reg.atom_count    <= ATOM_W'(16);
            cfg_reg.beats         <= NB_W'(4);
            cfg_reg.lengths       <= 64'h4444_4444_4444_4444;
        end
        else
            cfg_reg <= cfg_next;
    end

    // sequencer: one FSM stepping the datapath op by op
    bgg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (in_ready),
        .out_free (out_free),
        .out_load (out_load),
        .stat     (stat),
        .op       (op)
    );

    // counters, prefix table, shared divider and position adders
    bgg_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .cfg_wr (cfg_we),
        .in_cmd (s_tuser),
        .in_sf  (s_tdata[FRAME_W-1:0]),
        .op     (op),
        .stat   (stat),
        .res    (res)
    );

    assign s_tready = in_ready;

    // output register: the next item can be taken while a result waits here
    assign out_free = !m_valid_reg || m_tready;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (out_load)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= m_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            m_res_reg <= res;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_res_reg.subdiv, m_res_reg.beat, m_res_reg.measure,
                       m_res_reg.position};
    assign m_tuser  = {m_res_reg.crossed, m_res_reg.prominence};

endmodule

@@ sim/beat_grid_generator_top_tb.sv @@
`timescale 1ns / 1ps

module beat_grid_generator_top_tb;
    import bgg_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [30:0] search origin, [31] zero
    logic        s_tuser;   // cmd
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;   // [31:0] position, [47:32] measure, [51:48] beat, [55:52] subdiv
    logic [3:0]  m_tuser;   // [2:0] prominence, [3] segment_crossed

    beat_grid_generator_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // ---------------- grid predictor ----------------
    // Shadow of the config registers and of the grid counters.
    logic [30:0] g_start, g_end, g_dur;
    logic [15:0] g_first;
    logic [7:0]  g_atoms;
    logic [4:0]  g_beats;
    logic [63:0] g_lens;
    logic [15:0] g_meas;
    logic [3:0]  g_beat, g_sub;

    res_t grid_expected[$];

    int errors;
    int accepted_in;
    int accepted_out;
    int crossings;
    int start_cmds;
    int idle_cycles;

    function automatic int beat_count_eff();
        int n;
        n = int'(g_beats);
        if (n < 1) n = 1;
        if (n > MAX_BEATS) n = MAX_BEATS;
        return n;
    endfunction

    function automatic int beat_len(int b);
        int l;
        l = int'((g_lens >> (4 * (b & 15))) & 64'hF);
        return (l == 0) ? 1 : l;
    endfunction

    // Offset of (beat, subdiv) inside a measure, each term truncated.
    function automatic longint unsigned beat_offset(int b, int s);
        longint unsigned o, a, d;
        o = 0;
        a = (g_atoms == 0) ? 1 : g_atoms;
        d = g_dur;
        for (int i = 0; i < b && i < 16; i++)
            o += d * longint'(beat_len(i)) / a;
        return o + d * longint'(s) / a;
    endfunction

    function automatic longint unsigned grid_position();
        longint unsigned dm;
        dm = 16'(g_meas - g_first);
        return longint'(g_start) + dm * longint'(g_dur) + beat_offset(g_beat, g_sub);
    endfunction

    function automatic prom_t grid_prominence();
        if (g_meas == g_first && g_beat == 0 && g_sub == 0) return PROM_SEGMENT;
        if (g_sub == 0 && g_beat == 0) return PROM_MEASURE;
        if (g_sub == 0) return PROM_BEAT;
        if (beat_len(g_beat) % EVEN_DIV == 0 && g_sub % EVEN_DIV == 0) return PROM_EVEN;
        return PROM_OTHER;
    endfunction

    function automatic void grid_restart();
        g_meas = g_first;
        g_beat = 0;
        g_sub  = 0;
    endfunction

    // Search for first point at or after origin; returns 0 when no point is found.
    function automatic bit grid_search(longint unsigned origin);
        int nb;
        longint unsigned omax, k, base, o;
        longint need;
        nb = beat_count_eff();
        omax = 0;
        k = 0;
        for (int b = 0; b < nb; b++)
            for (int s = 0; s < beat_len(b); s++) begin
                o = beat_offset(b, s);
                if (o > omax) omax = o;
            end
        need = longint'(origin) - longint'(g_start) - longint'(omax);
        if (need > 0) begin
            if (g_dur == 0) return 0;
            k = (longint'(need) + g_dur - 1) / g_dur;
            if (k > 64'hFFFF) return 0;
        end
        base = longint'(g_start) + k * longint'(g_dur);
        for (int b = 0; b < nb; b++)
            for (int s = 0; s < beat_len(b); s++)
                if (base + beat_offset(b, s) >= origin) begin
                    g_meas = 16'(g_first + k);
                    g_beat = 4'(b);
                    g_sub  = 4'(s);
                    return 1;
                end
        return 0;
    endfunction

    function automatic res_t grid_step(logic cmd, logic [30:0] origin);
        res_t r;
        longint unsigned p;
        bit crossed;
        crossed = 0;
        if (cmd == CMD_START) begin
            if (grid_search(origin)) p = grid_position();
            else begin
                grid_restart();
                p = g_start;
            end
        end else begin
            if (g_sub + 1 >= beat_len(g_beat)) begin
                g_sub = 0;
                if (g_beat + 1 >= beat_count_eff()) begin
                    g_beat = 0;
                    g_meas = g_meas + 16'd1;
                end else g_beat = g_beat + 4'd1;
            end else g_sub = g_sub + 4'd1;
            p = grid_position();
            if (g_start != g_end && p >= g_end) begin
                grid_restart();
                p = g_start;
                crossed = 1;
            end
        end
        r.position   = p[31:0];
        r.prominence = grid_prominence();
        r.measure    = g_meas;
        r.beat       = g_beat;
        r.subdiv     = g_sub;
        r.crossed    = crossed;
        return r;
    endfunction

    // ---------------- idling control ----------------
    int src_idle_pct;
    int snk_idle_pct;
    bit snk_hold;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !snk_hold && ($urandom_range(99) >= snk_idle_pct);
    end

    // ---------------- result checker ----------------
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            res_t e;
            accepted_out++;
            if (grid_expected.size() == 0) begin
                $error("result with no expectation: tdata=%h tuser=%h", m_tdata, m_tuser);
                errors++;
            end else begin
                e = grid_expected.pop_front();
                if (m_tdata[31:0] !== e.position) begin
                    $error("position exp %0d got %0d", $signed(e.position),
                           $signed(m_tdata[31:0]));
                    errors++;
                end
                if (m_tuser[2:0] !== e.prominence) begin
                    $error("prominence exp %0d got %0d", e.prominence, m_tuser[2:0]);
                    errors++;
                end
                if (m_tdata[47:32] !== e.measure) begin
                    $error("measure_number exp %0d got %0d", e.measure, m_tdata[47:32]);
                    errors++;
                end
                if (m_tdata[51:48] !== e.beat) begin
                    $error("beat_number exp %0d got %0d", e.beat, m_tdata[51:48]);
                    errors++;
                end
                if (m_tdata[55:52] !== e.subdiv) begin
                    $error("subdiv_number exp %0d got %0d", e.subdiv, m_tdata[55:52]);
                    errors++;
                end
                if (m_tuser[3] !== e.crossed) begin
                    $error("segment_crossed exp %0d got %0d", e.crossed, m_tuser[3]);
                    errors++;
                end
                if (e.crossed) crossings++;
            end
        end
    end

    // ---------------- watchdog ----------------
    // Worst case: a start scan after a config write plus a long receiver hold;
    // QUIET_LIMIT is ample for both.
    localparam int QUIET_LIMIT = 40000;

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= QUIET_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ---------------- stimulus tasks ----------------
    task automatic cfg_write(cfg_idx_t idx, logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_SEG_START:  g_start = val[30:0];
            CFG_SEG_END:    g_end   = val[30:0];
            CFG_FIRST_MEAS: g_first = val[15:0];
            CFG_DURATION:   g_dur   = val[30:0];
            CFG_ATOMS:      g_atoms = val[7:0];
            CFG_BEATS:      g_beats = val[4:0];
            CFG_LENGTHS:    g_lens  = val;
            default: ;
        endcase
    endtask

    // Offer one item, hold until accepted; valid stays high between items with no idle drawn.
    task automatic send_item(logic cmd, logic [30:0] origin);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {1'b0, origin};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        grid_expected.push_back(grid_step(cmd, origin));
        accepted_in++;
        if (cmd == CMD_START) start_cmds++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (grid_expected.size() != 0) @(posedge clk);
        // block holds one item in flight; give it a generous settle
        repeat (100) @(posedge clk);
    endtask

    task automatic set_grid(logic [30:0] st, logic [30:0] en, logic [15:0] fm,
                            logic [30:0] du, logic [7:0] at, logic [4:0] bp,
                            logic [63:0] ln);
        cfg_write(CFG_SEG_START, st);
        cfg_write(CFG_SEG_END, en);
        cfg_write(CFG_FIRST_MEAS, fm);
        cfg_write(CFG_DURATION, du);
        cfg_write(CFG_ATOMS, at);
        cfg_write(CFG_BEATS, bp);
        cfg_write(CFG_LENGTHS, ln);
    endtask

    // Random config: mostly small meters so start scans stay short.
    task automatic random_grid();
        logic [63:0] ln;
        logic [30:0] st, du;
        ln = {$urandom, $urandom};
        st = ($urandom_range(3) == 0) ? 31'($urandom) : 31'($urandom_range(100000));
        du = ($urandom_range(7) == 0) ? 31'($urandom) : 31'($urandom_range(1, 200000));
        set_grid(st,
                 ($urandom_range(2) == 0) ? st : 31'(st + $urandom_range(1, 3000000)),
                 ($urandom_range(3) == 0) ? 16'hFFFF - 16'($urandom_range(3))
                                          : 16'($urandom),
                 du,
                 8'($urandom_range(0, 255)),
                 ($urandom_range(4) == 0) ? 5'($urandom) : 5'($urandom_range(1, 6)),
                 ln);
    endtask

    // ---------------- directed table ----------------
    typedef struct {
        logic        cmd;
        logic [30:0] origin;
        bit          has_exp;
        res_t        exp_res;
    } row_t;

    row_t dir_rows[$];

    function automatic res_t mk(logic [31:0] p, prom_t pr, logic [15:0] m,
                                logic [3:0] b, logic [3:0] s, logic c);
        res_t r;
        r.position = p; r.prominence = pr; r.measure = m;
        r.beat = b; r.subdiv = s; r.crossed = c;
        return r;
    endfunction

    function automatic void add_row(logic cmd, logic [30:0] o, bit he, res_t e);
        row_t r;
        r.cmd = cmd; r.origin = o; r.has_exp = he; r.exp_res = e;
        dir_rows.push_back(r);
    endfunction

    initial begin
        res_t none;
        bit   is_start;
        none = '0;
        errors = 0; accepted_in = 0; accepted_out = 0;
        crossings = 0; start_cmds = 0; idle_cycles = 0;
        src_idle_pct = 0; snk_idle_pct = 0; snk_hold = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = CMD_START;
        // reset defaults of the shadow copy
        g_start = 0; g_end = 0; g_first = 0; g_dur = 96000; g_atoms = 16;
        g_beats = 4; g_lens = 64'h4444444444444444;
        g_meas = 0; g_beat = 0; g_sub = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Defaults: 4 beats of 4, 6000 frames per atom.
        add_row(CMD_NEXT,  0,     1, mk(6000, PROM_OTHER, 0, 0, 1, 0));
        add_row(CMD_NEXT,  0,     1, mk(12000, PROM_EVEN, 0, 0, 2, 0));
        add_row(CMD_START, 0,     1, mk(0, PROM_SEGMENT, 0, 0, 0, 0));
        add_row(CMD_START, 24000, 1, mk(24000, PROM_BEAT, 0, 1, 0, 0));
        add_row(CMD_START, 96001, 1, mk(102000, PROM_OTHER, 1, 0, 1, 0));
        add_row(CMD_START, 96000, 1, mk(96000, PROM_MEASURE, 1, 0, 0, 0));
        // top frame: lands in measure 22369, beat 2, subdiv 2, past 2^31
        add_row(CMD_START, 31'h7FFFFFFF, 1,
                mk(32'd2147484000, PROM_EVEN, 16'd22369, 2, 2, 0));
        for (int i = 0; i < 6; i++) add_row(CMD_NEXT, 31'($urandom), 0, none);
        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].cmd, dir_rows[i].origin);
            if (dir_rows[i].has_exp && grid_expected[$] !== dir_rows[i].exp_res) begin
                $error("directed row %0d: predictor disagrees with table", i);
                errors++;
            end
        end
        drain();

        // Extremes: zero beats/atoms/lengths, finite end, measure wrap.
        set_grid(31'h7FFFFF00, 31'h7FFFFF80, 16'hFFFF, 31'h7FFFFFFF, 8'd0, 5'd0, 64'd0);
        for (int i = 0; i < 4; i++) send_item(CMD_NEXT, 31'h7FFFFFFF);
        send_item(CMD_START, 31'h7FFFFFFF);
        drain();
        set_grid(100, 100, 16'hFFFE, 1000, 8'd240, 5'd31, 64'hFFFFFFFFFFFFFFFF);
        send_item(CMD_START, 31'd5000);
        for (int i = 0; i < 6; i++) send_item(CMD_NEXT, 0);
        drain();
        set_grid(0, 2500, 16'd7, 1000, 8'd7, 5'd3, 64'h0000000000000A32);
        for (int i = 0; i < 12; i++) send_item(CMD_NEXT, 0);
        drain();

        // Random phases: three idling profiles, each with fresh configs.
        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 84 : 0;
            snk_idle_pct = (ph == 0) ? 84 : (ph == 1) ? 10 : 0;
            for (int blk = 0; blk < 10; blk++) begin
                random_grid();
                for (int i = 0; i < 53; i++) begin
                    is_start = ($urandom_range(9) == 0);
                    send_item(is_start ? CMD_START : CMD_NEXT,
                              ($urandom_range(1) == 0) ? 31'($urandom)
                                  : 31'(g_start + $urandom_range(400000)));
                end
                drain();
            end
        end

        // Long receiver hold while items keep coming: input must stall.
        fork
            begin
                snk_hold = 1;
                repeat (3000) @(posedge clk);
                snk_hold = 0;
            end
            for (int i = 0; i < 8; i++) send_item(CMD_NEXT, 0);
        join
        drain();

        $display("Covered %0d items in, %0d results out, %0d start searches, %0d crossings.",
                 accepted_in, accepted_out, start_cmds, crossings);
        $display("Configs swept extremes of every register under three idling profiles.");
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
